@@ hw/rtl/rfc_pkg.sv @@
// Shared constants and the CRC byte update for the response frame checker.
`default_nettype none

package rfc_pkg;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_SEED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY = 1'd1;

   localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_RESET = 16'h8408;

   // address, command, status and two CRC bytes
   localparam logic [7:0] MIN_LEN = 8'd5;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] RES_OK    = 2'd0;
   localparam logic [1:0] RES_SHORT = 2'd1;
   localparam logic [1:0] RES_CRC   = 2'd2;

   // Reflected CRC-16, one byte folded in, LSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/response_frame_checker.sv @@
// Top level: length-prefixed response frame parser with CRC-16 check.
`default_nettype none

// Parses a reader response byte stream: length L, address, command, status,
// L-5 payload bytes and a CRC-16 (reflected, seed and polynomial
// programmable through csr_) sent low byte first. Every payload byte comes
// out as a data item with its index; the last CRC byte produces a summary
// item with the header bytes, payload size and a result code (ok, too short,
// CRC mismatch). A frame with L below 5 consumes L more bytes unchecked and
// ends with a too-short summary, or at once when L is 0. One byte is taken
// per clock when not stalled; the byte's parsing and the unrolled eight-bit
// CRC update finish in the accept cycle and the result lands in the output
// register, so the result appears in the cycle after its byte. req_stall
// rises only while the output register holds an item that rsp_stall keeps
// from leaving. A new seed applies from the next length byte on.
module response_frame_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         csr_wr_en,
   input  wire logic [rfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rfc_pkg::CSR_DATA_W-1:0] csr_wdata,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_rx_byte,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_item_kind,
   output logic [7:0]                        rsp_payload_byte,
   output logic [7:0]                        rsp_payload_index,
   output logic [7:0]                        rsp_dev_addr,
   output logic [7:0]                        rsp_cmd_code,
   output logic [7:0]                        rsp_reader_status,
   output logic [7:0]                        rsp_payload_size,
   output logic [1:0]                        rsp_frame_result,
   output logic                              rsp_last
);

   import rfc_pkg::*;

   localparam logic [2:0] PH_LEN  = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_CMD  = 3'd2;
   localparam logic [2:0] PH_STAT = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CLO  = 3'd5;
   localparam logic [2:0] PH_CHI  = 3'd6;
   localparam logic [2:0] PH_SKIP = 3'd7;

   logic [15:0] seed_ff, seed_in;
   logic [15:0] poly_ff, poly_in;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [7:0]  pindex_ff, pindex_in;
   logic [7:0]  raddr_ff, raddr_in;
   logic [7:0]  rcmd_ff, rcmd_in;
   logic [7:0]  rstatus_ff, rstatus_in;
   logic [7:0]  psize_ff, psize_in;
   logic [1:0]  result_ff, result_in;
   logic        last_ff, last_in;

   logic        accept;
   logic        data_fire;
   logic        sum_fire;
   logic [7:0]  sum_size;
   logic [1:0]  sum_result;
   logic [7:0]  b;
   logic [15:0] rx_crc;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_rx_byte;
   assign rx_crc    = {b, crc_lo_ff};

   always_comb begin
      seed_in = seed_ff;
      poly_in = poly_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CRC_SEED: seed_in = csr_wdata;
            CSR_CRC_POLY: poly_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // frame parser: one byte per transfer
   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      crc_in          = crc_ff;
      addr_in         = addr_ff;
      cmd_in          = cmd_ff;
      status_in       = status_ff;
      crc_lo_in       = crc_lo_ff;
      data_fire       = 1'b0;
      sum_fire        = 1'b0;
      sum_size        = 8'd0;
      sum_result      = RES_OK;
      if (accept) begin
         case (phase_ff)
            PH_LEN: begin
               frame_length_in = b;
               byte_count_in   = 8'd0;
               addr_in         = 8'd0;
               cmd_in          = 8'd0;
               status_in       = 8'd0;
               crc_in          = crc_feed(seed_ff, b, poly_ff);
               if (b < MIN_LEN) begin
                  bytes_left_in = b;
                  if (b == 8'd0) begin
                     sum_fire   = 1'b1;
                     sum_result = RES_SHORT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  bytes_left_in = b - MIN_LEN;
                  phase_in      = PH_ADDR;
               end
            end
            PH_SKIP: begin
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_ff == 8'd1) begin
                  phase_in   = PH_LEN;
                  sum_fire   = 1'b1;
                  sum_result = RES_SHORT;
               end
            end
            PH_ADDR: begin
               addr_in  = b;
               crc_in   = crc_feed(crc_ff, b, poly_ff);
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = b;
               crc_in   = crc_feed(crc_ff, b, poly_ff);
               phase_in = PH_STAT;
            end
            PH_STAT: begin
               status_in = b;
               crc_in    = crc_feed(crc_ff, b, poly_ff);
               phase_in  = (bytes_left_ff == 8'd0) ? PH_CLO : PH_DATA;
            end
            PH_DATA: begin
               crc_in        = crc_feed(crc_ff, b, poly_ff);
               data_fire     = 1'b1;
               byte_count_in = byte_count_ff + 8'd1;
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_ff == 8'd1) begin
                  phase_in = PH_CLO;
               end
            end
            PH_CLO: begin
               crc_lo_in = b;
               phase_in  = PH_CHI;
            end
            default: begin
               phase_in   = PH_LEN;
               sum_fire   = 1'b1;
               sum_size   = frame_length_ff - MIN_LEN;
               sum_result = (rx_crc == crc_ff) ? RES_OK : RES_CRC;
            end
         endcase
      end
   end

   // output register: loads on a transfer in, holds while stalled
   always_comb begin
      rsp_valid_in = accept ? (data_fire | sum_fire) : (rsp_valid_ff & rsp_stall);
      kind_in      = kind_ff;
      pbyte_in     = pbyte_ff;
      pindex_in    = pindex_ff;
      raddr_in     = raddr_ff;
      rcmd_in      = rcmd_ff;
      rstatus_in   = rstatus_ff;
      psize_in     = psize_ff;
      result_in    = result_ff;
      last_in      = last_ff;
      if (data_fire) begin
         kind_in    = KIND_DATA;
         pbyte_in   = b;
         pindex_in  = byte_count_ff;
         raddr_in   = 8'd0;
         rcmd_in    = 8'd0;
         rstatus_in = 8'd0;
         psize_in   = 8'd0;
         result_in  = RES_OK;
         last_in    = 1'b0;
      end else if (sum_fire) begin
         kind_in    = KIND_SUMMARY;
         pbyte_in   = 8'd0;
         pindex_in  = 8'd0;
         raddr_in   = addr_in;
         rcmd_in    = cmd_in;
         rstatus_in = status_in;
         psize_in   = sum_size;
         result_in  = sum_result;
         last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= CRC_SEED_RESET;
         poly_ff         <= CRC_POLY_RESET;
         phase_ff        <= PH_LEN;
         bytes_left_ff   <= 8'd0;
         byte_count_ff   <= 8'd0;
         frame_length_ff <= 8'd0;
         crc_ff          <= CRC_SEED_RESET;
         addr_ff         <= 8'd0;
         cmd_ff          <= 8'd0;
         status_ff       <= 8'd0;
         crc_lo_ff       <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         seed_ff         <= seed_in;
         poly_ff         <= poly_in;
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         crc_ff          <= crc_in;
         addr_ff         <= addr_in;
         cmd_ff          <= cmd_in;
         status_ff       <= status_in;
         crc_lo_ff       <= crc_lo_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      pbyte_ff   <= pbyte_in;
      pindex_ff  <= pindex_in;
      raddr_ff   <= raddr_in;
      rcmd_ff    <= rcmd_in;
      rstatus_ff <= rstatus_in;
      psize_ff   <= psize_in;
      result_ff  <= result_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_payload_index = pindex_ff;
   assign rsp_dev_addr      = raddr_ff;
   assign rsp_cmd_code      = rcmd_ff;
   assign rsp_reader_status = rstatus_ff;
   assign rsp_payload_size  = psize_ff;
   assign rsp_frame_result  = result_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rfc_checker.sv @@
// Port-level assertions for the response frame checker, bound to the top level.
`default_nettype none

module rfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_item_kind,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [7:0] rsp_payload_size,
   input wire logic [1:0] rsp_frame_result,
   input wire logic       rsp_last
);

   import rfc_pkg::*;

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
                                 && $stable(rsp_item_kind))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free output register");

   // data items never close a frame; summaries always do
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_item_kind == KIND_SUMMARY))
                    && (rsp_item_kind == KIND_SUMMARY || rsp_frame_result == RES_OK))
      else $error("item kind and last disagree");

   a_short_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_SUMMARY && rsp_frame_result == RES_SHORT
      |-> rsp_payload_size == 8'd0)
      else $error("too-short summary with nonzero payload size");

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_item_kind    (rsp_item_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_payload_size (rsp_payload_size),
   .rsp_frame_result (rsp_frame_result),
   .rsp_last         (rsp_last)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for response_frame_checker: framed byte streams against a CRC-16 frame parser model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rfc_pkg::*;

   typedef enum logic [2:0] {
      PS_LENGTH, PS_ADDR, PS_CMD, PS_STATUS, PS_PAYLOAD, PS_CRC_LO, PS_CRC_HI, PS_SKIP
   } parse_state_type;

   typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_GARBAGE} frame_flavor_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] index;
      logic [7:0] addr;
      logic [7:0] cmd;
      logic [7:0] status;
      logic [7:0] size;
      logic [1:0] result;
      logic       last;
   } frame_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_item_kind;
   logic [7:0]            rsp_payload_byte;
   logic [7:0]            rsp_payload_index;
   logic [7:0]            rsp_dev_addr;
   logic [7:0]            rsp_cmd_code;
   logic [7:0]            rsp_reader_status;
   logic [7:0]            rsp_payload_size;
   logic [1:0]            rsp_frame_result;
   logic                  rsp_last;

   // parser model state and its copy of the registers
   logic [15:0]     cfg_seed = CRC_SEED_RESET;
   logic [15:0]     cfg_poly = CRC_POLY_RESET;
   parse_state_type ps_state = PS_LENGTH;
   logic [7:0]      ps_left = '0;
   logic [7:0]      ps_count = '0;
   logic [7:0]      ps_length = '0;
   logic [7:0]      ps_addr = '0;
   logic [7:0]      ps_cmd = '0;
   logic [7:0]      ps_status = '0;
   logic [7:0]      ps_crc_lo = '0;
   logic [15:0]     ps_crc = CRC_SEED_RESET;

   frame_item_type  frame_items_due[$];
   logic [7:0]      byte_queue[$];
   int              queued_bytes = 0;
   int              accepted_bytes = 0;
   int              error_count = 0;
   int              send_gap = 0;
   int              hold_left = 0;
   bit              idle_off = 1'b0;
   bit              want_long_hold = 1'b0;
   bit              long_hold_done = 1'b0;
   bit              req_fired = 1'b0;

   response_frame_checker i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_dev_addr      (rsp_dev_addr),
      .rsp_cmd_code      (rsp_cmd_code),
      .rsp_reader_status (rsp_reader_status),
      .rsp_payload_size  (rsp_payload_size),
      .rsp_frame_result  (rsp_frame_result),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bit-serial form: feedback is the low CRC bit xor the next data bit, LSB first
   function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b,
                                                   input logic [15:0] poly);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ poly;
         end
      end
      return c;
   endfunction

   function automatic frame_item_type frame_summary(input logic [7:0] size,
                                                    input logic [1:0] result);
      frame_item_type it;
      it        = '0;
      it.kind   = KIND_SUMMARY;
      it.addr   = ps_addr;
      it.cmd    = ps_cmd;
      it.status = ps_status;
      it.size   = size;
      it.result = result;
      it.last   = 1'b1;
      return it;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      frame_item_type it;
      logic [15:0]    rx_crc;
      case (ps_state)
         PS_LENGTH: begin
            ps_length = b;
            ps_count  = '0;
            ps_addr   = '0;
            ps_cmd    = '0;
            ps_status = '0;
            ps_crc    = crc16_fold_byte(cfg_seed, b, cfg_poly);
            if (b < MIN_LEN) begin
               ps_left = b;
               if (b == 8'd0) begin
                  frame_items_due.push_back(frame_summary(8'd0, RES_SHORT));
               end else begin
                  ps_state = PS_SKIP;
               end
            end else begin
               ps_left  = b - MIN_LEN;
               ps_state = PS_ADDR;
            end
         end
         PS_SKIP: begin
            ps_left = ps_left - 8'd1;
            if (ps_left == 8'd0) begin
               ps_state = PS_LENGTH;
               frame_items_due.push_back(frame_summary(8'd0, RES_SHORT));
            end
         end
         PS_ADDR: begin
            ps_addr  = b;
            ps_crc   = crc16_fold_byte(ps_crc, b, cfg_poly);
            ps_state = PS_CMD;
         end
         PS_CMD: begin
            ps_cmd   = b;
            ps_crc   = crc16_fold_byte(ps_crc, b, cfg_poly);
            ps_state = PS_STATUS;
         end
         PS_STATUS: begin
            ps_status = b;
            ps_crc    = crc16_fold_byte(ps_crc, b, cfg_poly);
            ps_state  = (ps_left == 8'd0) ? PS_CRC_LO : PS_PAYLOAD;
         end
         PS_PAYLOAD: begin
            ps_crc   = crc16_fold_byte(ps_crc, b, cfg_poly);
            it       = '0;
            it.kind  = KIND_DATA;
            it.data  = b;
            it.index = ps_count;
            frame_items_due.push_back(it);
            ps_count = ps_count + 8'd1;
            ps_left  = ps_left - 8'd1;
            if (ps_left == 8'd0) begin
               ps_state = PS_CRC_LO;
            end
         end
         PS_CRC_LO: begin
            ps_crc_lo = b;
            ps_state  = PS_CRC_HI;
         end
         default: begin
            rx_crc   = {b, ps_crc_lo};
            ps_state = PS_LENGTH;
            frame_items_due.push_back(frame_summary(ps_length - MIN_LEN,
                                                    (rx_crc == ps_crc) ? RES_OK : RES_CRC));
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   // sampling side: input transfers feed the model, output transfers are checked
   always @(posedge clock) begin
      frame_item_type want;
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_rx_byte);
            accepted_bytes++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_items_due.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = frame_items_due.pop_front();
               check_field("item_kind", rsp_item_kind, want.kind);
               check_field("payload_byte", rsp_payload_byte, want.data);
               check_field("payload_index", rsp_payload_index, want.index);
               check_field("dev_addr", rsp_dev_addr, want.addr);
               check_field("cmd_code", rsp_cmd_code, want.cmd);
               check_field("reader_status", rsp_reader_status, want.status);
               check_field("payload_size", rsp_payload_size, want.size);
               check_field("frame_result", rsp_frame_result, want.result);
               check_field("last", rsp_last, want.last);
            end
         end
      end
   end

   // byte driver: holds the payload until the transfer, idles in bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 19) == 0) begin
            send_gap = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: short stall bursts, plus one long hold so the input backs up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = 79;
         rsp_stall <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 15) == 0) begin
         hold_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CRC_SEED) begin
         cfg_seed = value;
      end else begin
         cfg_poly = value;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      queued_bytes++;
   endtask

   // every frame is its length byte plus that many bytes, so streams stay aligned
   task automatic queue_frame(input logic [7:0] len, input frame_flavor_type flavor,
                              input int fill);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = crc16_fold_byte(cfg_seed, len, cfg_poly);
      queue_byte(len);
      if (len < MIN_LEN || flavor == FRAME_GARBAGE) begin
         repeat (len) begin
            queue_byte(8'((fill < 0) ? $urandom_range(0, 255) : fill));
         end
      end else begin
         for (int i = 0; i < len - 2; i++) begin
            b   = 8'((fill < 0) ? $urandom_range(0, 255) : fill);
            crc = crc16_fold_byte(crc, b, cfg_poly);
            queue_byte(b);
         end
         if (flavor == FRAME_BAD_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         end
         queue_byte(crc[7:0]);
         queue_byte(crc[15:8]);
      end
   endtask

   task automatic queue_random_frames(input int n_bytes);
      int               first;
      int               pick;
      logic [7:0]       len;
      frame_flavor_type flavor;
      first = queued_bytes;
      while (queued_bytes - first < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            len = 8'($urandom_range(0, 4));
         end else if (pick < 82) begin
            len = 8'($urandom_range(5, 16));
         end else if (pick < 97) begin
            len = 8'($urandom_range(17, 60));
         end else begin
            len = 8'($urandom_range(61, 255));
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            flavor = FRAME_GOOD;
         end else if (pick < 90) begin
            flavor = FRAME_BAD_CRC;
         end else begin
            flavor = FRAME_GARBAGE;
         end
         queue_frame(len, flavor, -1);
      end
   endtask

   task automatic wait_drained();
      while (accepted_bytes != queued_bytes || frame_items_due.size() != 0) begin
         @(posedge clock);
      end
      // parser may still be mid-frame with nothing owed
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length, too-short frames, empty payload, all-ones and all-zeros content
      queue_frame(8'd0, FRAME_GOOD, 0);
      queue_frame(8'd1, FRAME_GOOD, 8'hFF);
      queue_frame(8'd3, FRAME_GOOD, 8'hA5);
      queue_frame(8'd5, FRAME_GOOD, 8'hFF);
      queue_frame(8'd6, FRAME_GOOD, 8'h00);
      queue_frame(8'd5, FRAME_BAD_CRC, 8'h00);
      wait_drained();

      write_csr(CSR_CRC_SEED, 16'h0000);
      write_csr(CSR_CRC_POLY, 16'hFFFF);
      queue_random_frames(180);
      wait_drained();

      write_csr(CSR_CRC_SEED, 16'hFFFF);
      write_csr(CSR_CRC_POLY, 16'h0001);
      want_long_hold = 1'b1;
      queue_random_frames(180);
      wait_drained();

      idle_off = 1'b1;
      write_csr(CSR_CRC_SEED, 16'($urandom_range(0, 65535)));
      write_csr(CSR_CRC_POLY, 16'($urandom_range(0, 65535)));
      queue_random_frames(150);
      queue_frame(8'd255, FRAME_GOOD, -1);
      wait_drained();

      idle_off = 1'b0;
      write_csr(CSR_CRC_SEED, 16'h1D0F);
      write_csr(CSR_CRC_POLY, 16'h0000);
      queue_random_frames(150);
      wait_drained();

      idle_off = 1'b1;
      write_csr(CSR_CRC_SEED, CRC_SEED_RESET);
      write_csr(CSR_CRC_POLY, CRC_POLY_RESET);
      queue_random_frames(150);
      wait_drained();

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/rfc_pkg.sv
hw/rtl/response_frame_checker.sv
hw/rtl/rfc_checker.sv
bench/tb_top.sv
